### sv/s_expression_tokenizer_core_macros.svh
// Assertion macros for the tokenizer
`ifndef S_EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define S_EXPRESSION_TOKENIZER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SXT_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: implication failed");

// Check that a condition implies another in the next cycle
`define SXT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: next-cycle implication failed");

`endif

### sv/sxt_pkg.sv
`timescale 1ns / 1ps
package sxt_pkg;

  localparam int unsigned FractionDigitsDefault = 9;

  typedef enum logic [14:0] {
    M_IDLE      = 15'h0001,
    M_COMMENT   = 15'h0002,
    M_STR       = 15'h0004,
    M_ESC       = 15'h0008,
    M_HEX1      = 15'h0010,
    M_HEX2      = 15'h0020,
    M_KW_START  = 15'h0040,
    M_SIGN      = 15'h0080,
    M_KW_SIGN   = 15'h0100,
    M_SYM_TRAIL = 15'h0200,
    M_KW_TRAIL  = 15'h0400,
    M_DEC       = 15'h0800,
    M_RADIX     = 15'h1000,
    M_FRAC      = 15'h2000,
    M_ERR       = 15'h4000
  } mode_e;

  localparam logic [3:0] TokOpen    = 4'd0;
  localparam logic [3:0] TokClose   = 4'd1;
  localparam logic [3:0] TokQuote   = 4'd2;
  localparam logic [3:0] TokEnd     = 4'd3;
  localparam logic [3:0] TokInt     = 4'd4;
  localparam logic [3:0] TokFloat   = 4'd5;
  localparam logic [3:0] TokString  = 4'd6;
  localparam logic [3:0] TokSymbol  = 4'd7;
  localparam logic [3:0] TokKeyword = 4'd8;
  localparam logic [3:0] TokError   = 4'd9;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrDigit   = 2'd1;
  localparam logic [1:0] ErrQuote   = 2'd2;
  localparam logic [1:0] ErrIdent   = 2'd3;

  localparam logic [7:0] NoDigit = 8'd99;

  // one result: 1+4+8+32+30+4+1+2+20+16 = 118 bits (tlast separate)
  typedef struct packed {
    logic [15:0] col;
    logic [19:0] line;
    logic [1:0]  err;
    logic        neg;
    logic [3:0]  fcnt;
    logic [29:0] fval;
    logic [31:0] ival;
    logic [7:0]  byte_v;
    logic [3:0]  ttype;
    logic        rec;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d;
  endfunction

  function automatic logic is_sym_alpha(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2e, 8'h2f, 8'h3c, 8'h3d,
      8'h3e, 8'h3f, 8'h5b, 8'h5d, 8'h5e, 8'h5f, 8'h7b, 8'h7c, 8'h7d: r = 1'b1;
      default: r = is_alpha(c);
    endcase
    return r;
  endfunction

  function automatic logic is_trail(input logic [7:0] c);
    return is_sym_alpha(c) || is_digit(c) || is_sign(c);
  endfunction

  function automatic logic [7:0] alnum_val(input logic [7:0] c);
    logic [7:0] r;
    if (is_digit(c)) r = c - 8'h30;
    else if (is_alpha(c)) r = (c | 8'h20) - 8'h61 + 8'd10;
    else r = NoDigit;
    return r;
  endfunction

endpackage

### sv/s_expression_tokenizer_core.sv
`timescale 1ns / 1ps
// S-expression tokenizer. At most one byte transfer per clock: every input is
// lexed and yields zero, one or two result transfers, which sit in a three-entry
// output queue. A result is queued at the edge that takes its byte and is offered
// once the results ahead of it have gone. Input is taken whenever at most one
// result is waiting, so the rate is one byte per cycle while each byte yields at
// most one result and the output side keeps up; a byte that yields two results
// can hold input off until the output has taken one. A radix digit costs one
// 32x32 multiply-add in the cycle its byte is taken. Input tdata: in_byte; tuser:
// kind (1 = end of input). Results are payload bytes and token records; after an
// error, bytes are dropped until end of input.
`include "s_expression_tokenizer_core_macros.svh"
module s_expression_tokenizer_core #(
  parameter int unsigned FRACTION_DIGITS = sxt_pkg::FractionDigitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tuser,   // [0] kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte, [39:8] int_value, [69:40] frac_value, [73:70] frac_count,
  // [74] negative, [76:75] error_code, [96:77] line_number,
  // [112:97] column_number, [119:113] zero
  output logic [119:0] m_axis_tdata,
  // [0] record, [4:1] tok_kind
  output logic [4:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import sxt_pkg::*;

  mode_e       mode_q, mode_d;
  logic [31:0] acc_q, acc_d, radix_q, radix_d;
  logic [29:0] frac_q, frac_d;
  logic [3:0]  fcnt_q, fcnt_d, hex_q, hex_d;
  logic        neg_q, neg_d;
  logic [19:0] line_q, line_d;
  logic [15:0] col_q, col_d;

  res_t        fifo_q [3];
  logic        flast_q [3];
  logic [1:0]  rd_q, cnt_q;
  logic [1:0]  wr0, wr1;
  logic        pop;

  res_t        r0, r1;
  logic [1:0]  n;
  logic        take;

  function automatic logic [1:0] slot_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign s_axis_tready = (cnt_q <= 2'd1);
  assign take = s_axis_tvalid && s_axis_tready;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign wr0 = (cnt_q == 2'd0) ? rd_q : slot_inc(rd_q);
  assign wr1 = slot_inc(wr0);

  function automatic res_t mk(input logic rec, input logic [3:0] t, input logic [7:0] b);
    res_t r;
    r = '0;
    r.rec = rec;
    r.ttype = t;
    r.byte_v = b;
    return r;
  endfunction

  always_comb begin
    logic [7:0]  c, v;
    logic [15:0] bumped;
    logic        fin, disp;
    res_t        fr;
    logic        fhas;
    c = s_axis_tdata;
    v = alnum_val(c);
    bumped = col_q + 16'd1;
    mode_d = mode_q; acc_d = acc_q; radix_d = radix_q; frac_d = frac_q;
    fcnt_d = fcnt_q; hex_d = hex_q; neg_d = neg_q; line_d = line_q; col_d = col_q;
    r0 = '0; r1 = '0; n = 2'd0; fin = 1'b0; disp = 1'b0;
    fr = '0; fhas = 1'b0;
    // pending token record
    unique case (mode_q)
      M_SIGN, M_SYM_TRAIL: begin fr = mk(1'b1, TokSymbol, 8'd0); fhas = 1'b1; end
      M_KW_SIGN, M_KW_TRAIL: begin fr = mk(1'b1, TokKeyword, 8'd0); fhas = 1'b1; end
      M_DEC, M_RADIX: begin
        fr = mk(1'b1, TokInt, 8'd0);
        fr.ival = neg_q ? (32'd0 - acc_q) : acc_q;
        fhas = 1'b1;
      end
      M_FRAC: begin
        fr = mk(1'b1, TokFloat, 8'd0);
        fr.ival = acc_q; fr.fval = frac_q; fr.fcnt = fcnt_q; fr.neg = neg_q;
        fhas = 1'b1;
      end
      default: ;
    endcase
    if (s_axis_tuser) begin
      r0 = mk(1'b1, TokError, 8'd0);
      r0.line = line_q;
      r0.col = col_q;
      unique case (mode_q)
        M_ERR: ;
        M_STR: begin r0.err = ErrQuote; n = 2'd1; end
        M_ESC: begin r0.err = ErrQuote; r0.col = bumped; n = 2'd1; end
        M_HEX1, M_HEX2: begin r0.err = ErrDigit; r0.col = bumped; n = 2'd1; end
        M_KW_START: begin r0.err = ErrIdent; n = 2'd1; end
        default: begin
          if (fhas) begin r0 = fr; r1 = mk(1'b1, TokEnd, 8'd0); n = 2'd2; end
          else begin r0 = mk(1'b1, TokEnd, 8'd0); n = 2'd1; end
        end
      endcase
      mode_d = M_IDLE; acc_d = '0; radix_d = '0; frac_d = '0; fcnt_d = '0;
      hex_d = '0; neg_d = 1'b0; line_d = 20'd1; col_d = '0;
    end else if (mode_q != M_ERR) begin
      if (c == 8'h0a) begin line_d = line_q + 20'd1; col_d = '0; end
      else col_d = bumped;
      r0 = mk(1'b1, TokError, 8'd0);
      r0.line = line_d; r0.col = col_d;
      unique case (mode_q)
        M_COMMENT: if (c == 8'h0a) mode_d = M_IDLE;
        M_STR: begin
          if (c == 8'h22) begin r0 = mk(1'b1, TokString, 8'd0); n = 2'd1; mode_d = M_IDLE; end
          else if (c == 8'h5c) mode_d = M_ESC;
          else begin r0 = mk(1'b0, TokString, c); n = 2'd1; end
        end
        M_ESC: begin
          mode_d = M_STR; n = 2'd1;
          unique case (c)
            8'h61: r0 = mk(1'b0, TokString, 8'h07);
            8'h62: r0 = mk(1'b0, TokString, 8'h08);
            8'h65: r0 = mk(1'b0, TokString, 8'h1b);
            8'h66: r0 = mk(1'b0, TokString, 8'h0c);
            8'h6e: r0 = mk(1'b0, TokString, 8'h0a);
            8'h72: r0 = mk(1'b0, TokString, 8'h0d);
            8'h74: r0 = mk(1'b0, TokString, 8'h09);
            8'h76: r0 = mk(1'b0, TokString, 8'h0b);
            8'h78: begin mode_d = M_HEX1; n = 2'd0; end
            default: r0 = mk(1'b0, TokString, c);
          endcase
        end
        M_HEX1: begin
          if (v < 8'd16) begin hex_d = v[3:0]; mode_d = M_HEX2; end
          else begin r0.err = ErrDigit; n = 2'd1; mode_d = M_ERR; end
        end
        M_HEX2: begin
          if (v < 8'd16) begin r0 = mk(1'b0, TokString, {hex_q, v[3:0]}); n = 2'd1;
            mode_d = M_STR; end
          else begin r0.err = ErrDigit; n = 2'd1; mode_d = M_ERR; end
        end
        M_KW_START: begin
          if (is_sign(c)) begin r0 = mk(1'b0, TokKeyword, c); n = 2'd1; mode_d = M_KW_SIGN; end
          else if (is_sym_alpha(c)) begin r0 = mk(1'b0, TokKeyword, c); n = 2'd1;
            mode_d = M_KW_TRAIL; end
          else begin r0.err = ErrIdent; r0.line = line_q; r0.col = col_q; n = 2'd1;
            mode_d = M_ERR; end
        end
        M_SIGN: begin
          if (is_digit(c)) begin acc_d = {24'd0, c - 8'h30}; mode_d = M_DEC; end
          else if (is_sign(c) || is_sym_alpha(c)) begin r0 = mk(1'b0, TokSymbol, c);
            n = 2'd1; mode_d = M_SYM_TRAIL; end
          else fin = 1'b1;
        end
        M_KW_SIGN: begin
          if (is_sign(c) || is_sym_alpha(c)) begin r0 = mk(1'b0, TokKeyword, c);
            n = 2'd1; mode_d = M_KW_TRAIL; end
          else fin = 1'b1;
        end
        M_SYM_TRAIL: begin
          if (is_trail(c)) begin r0 = mk(1'b0, TokSymbol, c); n = 2'd1; end
          else fin = 1'b1;
        end
        M_KW_TRAIL: begin
          if (is_trail(c)) begin r0 = mk(1'b0, TokKeyword, c); n = 2'd1; end
          else fin = 1'b1;
        end
        M_DEC: begin
          if (is_digit(c)) acc_d = acc_q * 32'd10 + {24'd0, c - 8'h30};
          else if (c == 8'h78) begin
            radix_d = (acc_q != '0) ? acc_q : 32'd16; acc_d = '0; mode_d = M_RADIX;
          end else if (c == 8'h2e) begin
            frac_d = '0; fcnt_d = '0; mode_d = M_FRAC;
          end else fin = 1'b1;
        end
        M_RADIX: begin
          if (v == NoDigit) fin = 1'b1;
          else if (!radix_q[31] && ({24'd0, v} < radix_q))
            acc_d = acc_q * radix_q + {24'd0, v};
          else begin r0.err = ErrDigit; n = 2'd1; mode_d = M_ERR; end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            if (fcnt_q < 4'(FRACTION_DIGITS)) begin
              frac_d = 30'(frac_q * 30'd10 + {22'd0, c - 8'h30});
              fcnt_d = fcnt_q + 4'd1;
            end
          end else fin = 1'b1;
        end
        default: disp = 1'b1;
      endcase
      if (fin) disp = 1'b1;
      if (disp) begin
        res_t d;
        logic dh;
        d = mk(1'b1, TokError, 8'd0); d.err = ErrIdent; d.line = line_q; d.col = col_q;
        dh = 1'b1;
        mode_d = M_IDLE; neg_d = 1'b0; acc_d = '0;
        if (is_space(c)) dh = 1'b0;
        else if (c == 8'h28) d = mk(1'b1, TokOpen, 8'd0);
        else if (c == 8'h29) d = mk(1'b1, TokClose, 8'd0);
        else if (c == 8'h27) d = mk(1'b1, TokQuote, 8'd0);
        else if (c == 8'h3b) begin dh = 1'b0; mode_d = M_COMMENT; end
        else if (c == 8'h22) begin dh = 1'b0; mode_d = M_STR; end
        else if (c == 8'h3a) begin dh = 1'b0; mode_d = M_KW_START; end
        else if (is_sign(c)) begin d = mk(1'b0, TokSymbol, c); neg_d = (c == 8'h2d);
          mode_d = M_SIGN; end
        else if (is_digit(c)) begin dh = 1'b0; acc_d = {24'd0, c - 8'h30}; mode_d = M_DEC; end
        else if (is_sym_alpha(c)) begin d = mk(1'b0, TokSymbol, c); mode_d = M_SYM_TRAIL; end
        else mode_d = M_ERR;
        if (fin && fhas) begin
          r0 = fr; r1 = d; n = dh ? 2'd2 : 2'd1;
        end else begin
          r0 = d; n = dh ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; acc_q <= '0; radix_q <= '0; frac_q <= '0; fcnt_q <= '0;
      hex_q <= '0; neg_q <= 1'b0; line_q <= 20'd1; col_q <= '0;
    end else if (take) begin
      mode_q <= mode_d; acc_q <= acc_d; radix_q <= radix_d; frac_q <= frac_d;
      fcnt_q <= fcnt_d; hex_q <= hex_d; neg_q <= neg_d; line_q <= line_d; col_q <= col_d;
    end
  end

  // three-entry result ring, input taken while at most one result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= '0;
    end else begin
      cnt_q <= cnt_q + (take ? n : 2'd0) - (pop ? 2'd1 : 2'd0);
      if (pop) rd_q <= slot_inc(rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fifo_q[wr0] <= r0; flast_q[wr0] <= (n == 2'd1);
      fifo_q[wr1] <= r1; flast_q[wr1] <= 1'b1;
    end
  end

  res_t ro;
  assign ro = fifo_q[rd_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = flast_q[rd_q];
  assign m_axis_tuser  = {ro.ttype, ro.rec};
  assign m_axis_tdata  = {7'd0, ro.col, ro.line, ro.err, ro.neg, ro.fcnt, ro.fval,
                          ro.ival, ro.byte_v};

  `SXT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `SXT_ASSERT_IMPL(a_err_drop, clk_i, rst_ni, take && mode_q == M_ERR && !s_axis_tuser,
                   n == 2'd0)
  `SXT_ASSERT_IMPL(a_last_known, clk_i, rst_ni, m_axis_tvalid, !$isunknown(m_axis_tlast))
endmodule

### tb/tb_s_expression_tokenizer_core.sv
`timescale 1ns / 1ps
module tb_s_expression_tokenizer_core;
  import sxt_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE, L_COMMENT, L_STR, L_ESC, L_HEX1, L_HEX2, L_KW_START, L_SIGN,
    L_KW_SIGN, L_SYM_TRAIL, L_KW_TRAIL, L_DEC, L_RADIX, L_FRAC, L_ERR
  } lex_e;

  typedef struct packed {
    logic        eoi;
    logic [7:0]  ch;
  } byte_item_t;

  typedef struct packed {
    logic        rec;
    logic [3:0]  ttype;
    logic [7:0]  ch;
    logic [31:0] ival;
    logic [29:0] fval;
    logic [3:0]  fcnt;
    logic        neg;
    logic [1:0]  err;
    logic [19:0] line;
    logic [15:0] col;
    logic        last;
  } token_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic m_axis_tlast;

  s_expression_tokenizer_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_item_t pending_bytes[$];
  token_out_t expected_tokens[$];
  int mismatches = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 78;
  int hold_left = 0;
  bit in_taken = 1'b0;

  // predictor state
  lex_e        p_mode = L_IDLE;
  logic [31:0] p_acc = '0;
  logic [31:0] p_radix = '0;
  logic [29:0] p_frac = '0;
  logic [3:0]  p_fcnt = '0;
  logic        p_minus = 1'b0;
  logic [3:0]  p_hexhi = '0;
  logic [19:0] p_line = 20'd1;
  logic [15:0] p_col = '0;
  token_out_t  step_out[$];

  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit c_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic bit c_symch(logic [7:0] c);
    case (c)
      "!", "#", "$", "%", "&", "*", ".", "/", "<", "=", ">", "?", "[", "]", "^",
      "_", "{", "|", "}": return 1'b1;
      default: return c_alpha(c);
    endcase
  endfunction

  function automatic int alnum_code(logic [7:0] c);
    if (c_digit(c)) return c - "0";
    if (c_alpha(c)) return (c | 8'h20) - "a" + 10;
    return 99;
  endfunction

  function automatic void emit(logic rec, logic [3:0] t, logic [7:0] ch, logic [31:0] iv,
                               logic [29:0] fv, logic [3:0] fc, logic ng, logic [1:0] er,
                               logic [19:0] ln, logic [15:0] cl);
    token_out_t r;
    r = '{rec, t, ch, iv, fv, fc, ng, er, ln, cl, 1'b0};
    if (step_out.size() < 2) step_out.push_back(r);
  endfunction

  function automatic void emit_err(logic [1:0] code, logic [19:0] ln, logic [15:0] cl);
    emit(1, TokError, 0, 0, 0, 0, 0, code, ln, cl);
    p_mode = L_ERR;
  endfunction

  function automatic void close_token();
    case (p_mode)
      L_SIGN, L_SYM_TRAIL: emit(1, TokSymbol, 0, 0, 0, 0, 0, ErrNone, 0, 0);
      L_KW_SIGN, L_KW_TRAIL: emit(1, TokKeyword, 0, 0, 0, 0, 0, ErrNone, 0, 0);
      L_DEC, L_RADIX: emit(1, TokInt, 0, p_minus ? -p_acc : p_acc, 0, 0, 0, ErrNone, 0, 0);
      L_FRAC: emit(1, TokFloat, 0, p_acc, p_frac, p_fcnt, p_minus, ErrNone, 0, 0);
      default: ;
    endcase
    p_mode = L_IDLE;
  endfunction

  function automatic void start_token(logic [7:0] c, logic [19:0] ln, logic [15:0] cl);
    p_mode = L_IDLE;
    p_minus = 1'b0;
    p_acc = '0;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == "(") emit(1, TokOpen, 0, 0, 0, 0, 0, ErrNone, 0, 0);
    else if (c == ")") emit(1, TokClose, 0, 0, 0, 0, 0, ErrNone, 0, 0);
    else if (c == "'") emit(1, TokQuote, 0, 0, 0, 0, 0, ErrNone, 0, 0);
    else if (c == ";") p_mode = L_COMMENT;
    else if (c == "\"") p_mode = L_STR;
    else if (c == ":") p_mode = L_KW_START;
    else if (c_sign(c)) begin
      emit(0, TokSymbol, c, 0, 0, 0, 0, ErrNone, 0, 0);
      p_minus = (c == "-");
      p_mode = L_SIGN;
    end else if (c_digit(c)) begin
      p_acc = 32'(c - "0");
      p_mode = L_DEC;
    end else if (c_symch(c)) begin
      emit(0, TokSymbol, c, 0, 0, 0, 0, ErrNone, 0, 0);
      p_mode = L_SYM_TRAIL;
    end else emit_err(ErrIdent, ln, cl);
  endfunction

  function automatic void lex_byte(byte_item_t it);
    logic [7:0] c;
    logic [19:0] ln;
    logic [15:0] cl;
    int v;
    c = it.ch;
    ln = p_line;
    cl = p_col;
    step_out.delete();
    if (it.eoi) begin
      case (p_mode)
        L_ERR: ;
        L_STR: emit_err(ErrQuote, ln, cl);
        L_ESC: emit_err(ErrQuote, ln, cl + 16'd1);
        L_HEX1, L_HEX2: emit_err(ErrDigit, ln, cl + 16'd1);
        L_KW_START: emit_err(ErrIdent, ln, cl);
        default: begin
          close_token();
          emit(1, TokEnd, 0, 0, 0, 0, 0, ErrNone, 0, 0);
        end
      endcase
      p_mode = L_IDLE; p_acc = '0; p_radix = '0; p_frac = '0; p_fcnt = '0;
      p_minus = 1'b0; p_hexhi = '0; p_line = 20'd1; p_col = '0;
    end else if (p_mode != L_ERR) begin
      if (c == 8'h0a) begin
        p_line = p_line + 20'd1;
        p_col = '0;
      end else p_col = p_col + 16'd1;
      case (p_mode)
        L_COMMENT: if (c == 8'h0a) p_mode = L_IDLE;
        L_STR: begin
          if (c == "\"") begin
            emit(1, TokString, 0, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_IDLE;
          end else if (c == "\\") p_mode = L_ESC;
          else emit(0, TokString, c, 0, 0, 0, 0, ErrNone, 0, 0);
        end
        L_ESC: begin
          p_mode = L_STR;
          case (c)
            "a": emit(0, TokString, 8'h07, 0, 0, 0, 0, ErrNone, 0, 0);
            "b": emit(0, TokString, 8'h08, 0, 0, 0, 0, ErrNone, 0, 0);
            "e": emit(0, TokString, 8'h1b, 0, 0, 0, 0, ErrNone, 0, 0);
            "f": emit(0, TokString, 8'h0c, 0, 0, 0, 0, ErrNone, 0, 0);
            "n": emit(0, TokString, 8'h0a, 0, 0, 0, 0, ErrNone, 0, 0);
            "r": emit(0, TokString, 8'h0d, 0, 0, 0, 0, ErrNone, 0, 0);
            "t": emit(0, TokString, 8'h09, 0, 0, 0, 0, ErrNone, 0, 0);
            "v": emit(0, TokString, 8'h0b, 0, 0, 0, 0, ErrNone, 0, 0);
            "x": p_mode = L_HEX1;
            default: emit(0, TokString, c, 0, 0, 0, 0, ErrNone, 0, 0);
          endcase
        end
        L_HEX1: begin
          v = alnum_code(c);
          if (v < 16) begin
            p_hexhi = 4'(v);
            p_mode = L_HEX2;
          end else emit_err(ErrDigit, p_line, p_col);
        end
        L_HEX2: begin
          v = alnum_code(c);
          if (v < 16) begin
            emit(0, TokString, {p_hexhi, 4'(v)}, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_STR;
          end else emit_err(ErrDigit, p_line, p_col);
        end
        L_KW_START: begin
          if (c_sign(c)) begin
            emit(0, TokKeyword, c, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_KW_SIGN;
          end else if (c_symch(c)) begin
            emit(0, TokKeyword, c, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_KW_TRAIL;
          end else emit_err(ErrIdent, ln, cl);
        end
        L_SIGN: begin
          if (c_digit(c)) begin
            p_acc = 32'(c - "0");
            p_mode = L_DEC;
          end else if (c_sign(c) || c_symch(c)) begin
            emit(0, TokSymbol, c, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_SYM_TRAIL;
          end else begin
            close_token();
            start_token(c, ln, cl);
          end
        end
        L_KW_SIGN: begin
          if (c_sign(c) || c_symch(c)) begin
            emit(0, TokKeyword, c, 0, 0, 0, 0, ErrNone, 0, 0);
            p_mode = L_KW_TRAIL;
          end else begin
            close_token();
            start_token(c, ln, cl);
          end
        end
        L_SYM_TRAIL, L_KW_TRAIL: begin
          if (c_symch(c) || c_digit(c) || c_sign(c))
            emit(0, p_mode == L_SYM_TRAIL ? TokSymbol : TokKeyword, c, 0, 0, 0, 0,
                 ErrNone, 0, 0);
          else begin
            close_token();
            start_token(c, ln, cl);
          end
        end
        L_DEC: begin
          if (c_digit(c)) p_acc = p_acc * 32'd10 + 32'(c - "0");
          else if (c == "x") begin
            p_radix = (p_acc != 0) ? p_acc : 32'd16;
            p_acc = '0;
            p_mode = L_RADIX;
          end else if (c == ".") begin
            p_frac = '0;
            p_fcnt = '0;
            p_mode = L_FRAC;
          end else begin
            close_token();
            start_token(c, ln, cl);
          end
        end
        L_RADIX: begin
          v = alnum_code(c);
          if (v == 99) begin
            close_token();
            start_token(c, ln, cl);
          end else if (!p_radix[31] && 32'(v) < p_radix) p_acc = p_acc * p_radix + 32'(v);
          else emit_err(ErrDigit, p_line, p_col);
        end
        L_FRAC: begin
          if (c_digit(c)) begin
            if (p_fcnt < 4'(FractionDigitsDefault)) begin
              p_frac = p_frac * 30'd10 + 30'(c - "0");
              p_fcnt = p_fcnt + 4'd1;
            end
          end else begin
            close_token();
            start_token(c, ln, cl);
          end
        end
        default: start_token(c, ln, cl);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
  endfunction

  // receiver hold-off, counted down in cycles
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_bytes[0].eoi;
          s_axis_tdata <= pending_bytes[0].ch;
          void'(pending_bytes.pop_front());
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    token_out_t got, want;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tuser[4:1], m_axis_tdata[7:0], m_axis_tdata[39:8],
              m_axis_tdata[69:40], m_axis_tdata[73:70], m_axis_tdata[74],
              m_axis_tdata[76:75], m_axis_tdata[96:77], m_axis_tdata[112:97],
              m_axis_tlast};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want || m_axis_tdata[119:113] !== '0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", want, got);
        end
      end
    end
    if (in_taken) lex_byte('{s_axis_tuser, s_axis_tdata});
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back('{1'b0, s[i]});
  endfunction

  function automatic void push_eoi();
    pending_bytes.push_back('{1'b1, 8'h00});
  endfunction

  function automatic string rand_atom();
    string s;
    int n;
    case ($urandom_range(9))
      0: s = $sformatf("%0d", $urandom_range(99999));
      1: s = $sformatf("-%0d.%0d", $urandom_range(999), $urandom());
      2: s = $sformatf("%0dx%0h", $urandom_range(16), $urandom_range(4095));
      3: s = $sformatf("0x%0h", $urandom());
      4: s = "\"ab\\n\\x4F\\q\"";
      5: s = ":key-1";
      6: s = "+sym?";
      7: s = "; note\n";
      8: s = "'(";
      default: begin
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
      end
    endcase
    return s;
  endfunction

  function automatic void gen_random(int count);
    int added;
    string s;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 8) begin
        pending_bytes.push_back('{1'b0, 8'($urandom())});
        added++;
      end else begin
        s = rand_atom();
        push_text(s);
        added += s.len();
      end
      push_text($urandom_range(3) == 0 ? "\n" : " ");
      added++;
      if ($urandom_range(99) < 4) begin
        push_eoi();
        added++;
      end
    end
    push_eoi();
  endfunction

  task automatic drain();
    while (pending_bytes.size() > 0 || s_axis_tvalid || expected_tokens.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    pending_bytes.push_back('{1'b0, 8'hff});
    push_eoi();
    push_text("('x) -12.5 +3");
    push_eoi();
    push_text("0xFF 2x101 :+ :a \"\\e\\x7G");
    push_eoi();
    push_text("\"s");
    push_eoi();
    push_text(";c");
    push_eoi();
    push_text(":");
    push_eoi();
    push_text("3x3 ~");
    push_eoi();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    gen_random(300);
    drain();
    hold_left = 60;
    push_text("(abc def 12 :k)");
    wait (hold_left == 0);
    push_eoi();
    drain();
    send_idle_pct = 78;
    recv_idle_pct = 19;
    gen_random(350);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(350);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_tokens.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/sxt_pkg.sv
sv/s_expression_tokenizer_core.sv
tb/tb_s_expression_tokenizer_core.sv
